// ----- src/assert_macros.svh -----
// Assertion macros shared by the calendar date day adder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed: next-cycle implication.");

`endif

// ----- src/cdda_pkg.sv -----
// Package with the constants, types and calendar functions of the date day adder.
package cdda_pkg;

   localparam logic       ACTION_LOAD     = 1'b0;
   localparam logic       ACTION_ADVANCE  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [13:0] MAX_YEAR      = 14'd9999;
   localparam logic [3:0]  MONTH_FIRST   = 4'd1;
   localparam logic [3:0]  MONTH_LAST    = 4'd12;
   localparam logic [3:0]  MONTH_FEB     = 4'd2;
   localparam logic [4:0]  DAY_FIRST     = 5'd1;

   // Multiplicative inverse of 25 modulo 2**14 and the divisibility limit.
   localparam logic [13:0] DIV25_INV     = 14'd7209;
   localparam logic [13:0] DIV25_LIMIT   = 14'd655;

   typedef struct packed {
      logic        fits;
      logic [4:0]  day_sum;
      logic [15:0] inc_rest;
   } step_result_type;

   // Gregorian leap rule: y%100 == 0 is y%4 == 0 with 25 | y, y%400 adds 16 | y.
   function automatic logic is_leap(input logic [13:0] y);
      logic [13:0] prod;
      logic        div25;
      prod  = y * DIV25_INV;
      div25 = (prod <= DIV25_LIMIT);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- src/calendar_date_day_adder.sv -----
// Top level: loads or advances a stored Gregorian date under a small sequencer.
// A load passes through S_LEAP and S_CHECK, then raises the registered result strobe.
// An advance passes through S_LEAP and then S_STEP, staying in S_STEP while months are walked
// and returning to S_LEAP at each year crossed; the shared month step unit sets this pace.
// busy stays high until the result is shown; the next start is taken in that cycle.
// Synchronous reset sets the date to year 1, month 1, day 1 with no result pending.
`include "assert_macros.svh"

module calendar_date_day_adder (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [13:0] req_new_year,
   input  logic [3:0]  req_new_month,
   input  logic [4:0]  req_new_day,
   input  logic [15:0] req_day_increment,
   output logic        rsp_valid,
   output logic [13:0] rsp_cur_year,
   output logic [3:0]  rsp_cur_month,
   output logic [4:0]  rsp_cur_day,
   output logic [1:0]  rsp_status
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LEAP  = 2'd1;
   localparam logic [1:0] S_STEP  = 2'd2;
   localparam logic [1:0] S_CHECK = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [13:0] wy_ff, wy_in;
   logic [3:0]  wm_ff, wm_in;
   logic [4:0]  wd_ff, wd_in;
   logic [15:0] inc_ff, inc_in;
   logic        act_ff, act_in;
   logic        leap_ff, leap_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        load_ok;
   logic        date_sane;

   cdda_pkg::step_result_type step;

   cdda_step_unit u_step (
      .month  (wm_ff),
      .day    (wd_ff),
      .inc    (inc_ff),
      .leap   (leap_ff),
      .result (step)
   );

   always_comb begin
      state_in     = state_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      wy_in        = wy_ff;
      wm_in        = wm_ff;
      wd_in        = wd_ff;
      inc_in       = inc_ff;
      act_in       = act_ff;
      leap_in      = leap_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      load_ok      = (wy_ff != 14'd0) && (wy_ff <= cdda_pkg::MAX_YEAR)
                     && (wm_ff >= cdda_pkg::MONTH_FIRST) && (wm_ff <= cdda_pkg::MONTH_LAST)
                     && (wd_ff != 5'd0) && step.fits;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in   = req_action;
               state_in = S_LEAP;
               if (req_action == cdda_pkg::ACTION_LOAD) begin
                  wy_in  = req_new_year;
                  wm_in  = req_new_month;
                  wd_in  = req_new_day;
                  inc_in = 16'd0;
               end else begin
                  wy_in  = year_ff;
                  wm_in  = month_ff;
                  wd_in  = day_ff;
                  inc_in = req_day_increment;
               end
            end
         end
         S_LEAP: begin
            leap_in  = cdda_pkg::is_leap(wy_ff);
            state_in = (act_ff == cdda_pkg::ACTION_LOAD) ? S_CHECK : S_STEP;
         end
         S_CHECK: begin
            if (load_ok) begin
               year_in   = wy_ff;
               month_in  = wm_ff;
               day_in    = wd_ff;
               status_in = cdda_pkg::STATUS_OK;
            end else begin
               status_in = cdda_pkg::STATUS_BAD_DATE;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_STEP: begin
            if (step.fits) begin
               year_in      = wy_ff;
               month_in     = wm_ff;
               day_in       = step.day_sum;
               status_in    = cdda_pkg::STATUS_OK;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               inc_in = step.inc_rest;
               wd_in  = cdda_pkg::DAY_FIRST;
               if (wm_ff == cdda_pkg::MONTH_LAST) begin
                  wm_in = cdda_pkg::MONTH_FIRST;
                  if (wy_ff == cdda_pkg::MAX_YEAR) begin
                     status_in    = cdda_pkg::STATUS_OVERFLOW;
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     wy_in    = wy_ff + 14'd1;
                     state_in = S_LEAP;
                  end
               end else begin
                  wm_in = wm_ff + 4'd1;
                  if (wm_ff == 4'd1) begin
                     state_in = S_STEP;
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         year_ff      <= 14'd1;
         month_ff     <= cdda_pkg::MONTH_FIRST;
         day_ff       <= cdda_pkg::DAY_FIRST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         year_ff      <= year_in;
         month_ff     <= month_in;
         day_ff       <= day_in;
      end
   end

   always_ff @(posedge clock) begin
      wy_ff     <= wy_in;
      wm_ff     <= wm_in;
      wd_ff     <= wd_in;
      inc_ff    <= inc_in;
      act_ff    <= act_in;
      leap_ff   <= leap_in;
      status_ff <= status_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cur_year  = year_ff;
   assign rsp_cur_month = month_ff;
   assign rsp_cur_day   = day_ff;
   assign rsp_status    = status_ff;

   assign date_sane = (month_ff >= cdda_pkg::MONTH_FIRST) && (month_ff <= cdda_pkg::MONTH_LAST)
                      && (day_ff != 5'd0) && (year_ff != 14'd0);

   `ASSERT_NEXT(a_busy_after_transfer, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_result_when_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_IMPLIES(a_stored_date_sane, clock, reset, rsp_valid, date_sane)

endmodule

// ----- src/cdda_step_unit.sv -----
// Shared month step unit: fits the remaining count into the month or consumes the month.
module cdda_step_unit (
   input  logic [3:0]                month,
   input  logic [4:0]                day,
   input  logic [15:0]               inc,
   input  logic                      leap,
   output cdda_pkg::step_result_type result
);

   logic [4:0]  len;
   logic [16:0] sum;

   always_comb begin
      len             = cdda_pkg::month_len(month, leap);
      sum             = {1'b0, inc} + {12'd0, day};
      result.fits     = (sum <= {12'd0, len});
      result.day_sum  = sum[4:0];
      result.inc_rest = inc - {11'd0, len} + {11'd0, day} - 16'd1;
   end

endmodule
